[hw/rtl/aluf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_pkg
// Shared types and constants for the accumulator ALU: operation codes, word
// field widths and the positions of the flag bits.
// ----------------------------------------------------------------------------
package aluf_pkg;

   localparam int OP_W    = 5;
   localparam int DATA_W  = 8;
   localparam int BIDX_W  = 3;
   localparam int FLAGS_W = 4;

   // Flag bit positions within the flags field.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust corrections.
   localparam logic [DATA_W-1:0] DAA_LO_ADJ = 8'h06;
   localparam logic [DATA_W-1:0] DAA_HI_ADJ = 8'h60;
   localparam logic [DATA_W-1:0] DAA_HI_MAX = 8'h99;
   localparam logic [3:0]        DAA_LO_MAX = 4'd9;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_AND  = 5'd4,
      OP_OR   = 5'd5,
      OP_XOR  = 5'd6,
      OP_CP   = 5'd7,
      OP_INC  = 5'd8,
      OP_DEC  = 5'd9,
      OP_RLCA = 5'd10,
      OP_RLA  = 5'd11,
      OP_RRCA = 5'd12,
      OP_RRA  = 5'd13,
      OP_RLC  = 5'd14,
      OP_RL   = 5'd15,
      OP_RRC  = 5'd16,
      OP_RR   = 5'd17,
      OP_SLA  = 5'd18,
      OP_SRA  = 5'd19,
      OP_SRL  = 5'd20,
      OP_SWAP = 5'd21,
      OP_BIT  = 5'd22,
      OP_SET  = 5'd23,
      OP_RES  = 5'd24,
      OP_DAA  = 5'd25,
      OP_CPL  = 5'd26,
      OP_CCF  = 5'd27,
      OP_SCF  = 5'd28,
      OP_LOAD = 5'd29
   } alu_op_type;

endpackage

[hw/rtl/aluf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_req_if
// Request channel of the accumulator ALU: one operation word per handshake.
// ----------------------------------------------------------------------------
interface aluf_req_if
   import aluf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] operand;
   logic [BIDX_W-1:0] bit_index;

   modport source (output valid, output op, output operand, output bit_index, input ready);
   modport sink   (input valid, input op, input operand, input bit_index, output ready);
endinterface

[hw/rtl/aluf_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aluf_rsp_if
// Response channel of the accumulator ALU: one result word per handshake.
// ----------------------------------------------------------------------------
interface aluf_rsp_if
   import aluf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  value;
   logic [FLAGS_W-1:0] flags;

   modport source (output valid, output value, output flags, input ready);
   modport sink   (input valid, input value, input flags, output ready);
endinterface

[hw/rtl/accumulator_alu_with_flags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_unit
// 8-bit accumulator ALU with Z, N, H and C flags.
// ----------------------------------------------------------------------------
// Each request word carries an operation, an operand byte and a bit index and
// produces exactly one response word with the resulting value and flags. The
// unit is a two-stage pipeline: a request register, then one pass of ALU logic
// that updates the accumulator and flags and loads the response register. A
// new word is accepted every clock as long as the response side keeps up, so
// the sustained rate is one word per cycle. The response word is loaded from
// the request register, which holds its word while the response side stalls.
// The accumulator and flags are updated in the same cycle a word leaves the
// request register, so dependent operations issue back to back. Reset clears
// the accumulator and flags.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags_unit
   import aluf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   aluf_req_if.sink   req_bus,
   aluf_rsp_if.source rsp_bus
);

   // Request stage registers.
   logic              req_valid_ff;
   logic [OP_W-1:0]   req_op_ff;
   logic [DATA_W-1:0] req_operand_ff;
   logic [BIDX_W-1:0] req_bidx_ff;

   // Architectural state.
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [FLAGS_W-1:0] flags_ff, flags_in;

   // Response stage registers.
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_value_ff;
   logic [FLAGS_W-1:0] rsp_flags_ff;

   logic advance;
   logic req_take;

   // The ALU stage moves when the response register is free or being drained.
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign rsp_bus.flags = rsp_flags_ff;

   // ALU datapath.
   logic [DATA_W-1:0]  a, s, val;
   logic [FLAGS_W-1:0] f;
   logic               cin, c_use;
   logic [DATA_W:0]    sum9, dif9;
   logic [4:0]         hsum, hdif;
   logic [DATA_W-1:0]  bmask, daa_r;
   logic               daa_c;
   logic               write_acc;

   always_comb begin
      a     = acc_ff;
      s     = req_operand_ff;
      cin   = flags_ff[FLAG_C];
      c_use = ((req_op_ff == OP_ADC) || (req_op_ff == OP_SBC)) ? cin : 1'b0;

      sum9 = {1'b0, a} + {1'b0, s} + {{DATA_W{1'b0}}, c_use};
      dif9 = {1'b0, a} - {1'b0, s} - {{DATA_W{1'b0}}, c_use};
      hsum = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'd0, c_use};
      hdif = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'd0, c_use};

      bmask = {{(DATA_W-1){1'b0}}, 1'b1} << req_bidx_ff;

      // Decimal adjust uses N, H and C left by the previous operation.
      daa_r = a;
      daa_c = cin;
      if (!flags_ff[FLAG_N]) begin
         if (cin || (a > DAA_HI_MAX)) begin
            daa_r = daa_r + DAA_HI_ADJ;
            daa_c = 1'b1;
         end
         if (flags_ff[FLAG_H] || (daa_r[3:0] > DAA_LO_MAX)) begin
            daa_r = daa_r + DAA_LO_ADJ;
         end
      end else begin
         if (cin) begin
            daa_r = daa_r - DAA_HI_ADJ;
         end
         if (flags_ff[FLAG_H]) begin
            daa_r = daa_r - DAA_LO_ADJ;
         end
      end

      val       = a;
      f         = flags_ff;
      write_acc = 1'b1;

      unique case (req_op_ff)
         OP_ADD, OP_ADC: begin
            val = sum9[DATA_W-1:0];
            f   = {(val == '0), 1'b0, hsum[4], sum9[DATA_W]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            val = (req_op_ff == OP_CP) ? a : dif9[DATA_W-1:0];
            f   = {(dif9[DATA_W-1:0] == '0), 1'b1, hdif[4], dif9[DATA_W]};
         end
         OP_AND: begin
            val = a & s;
            f   = {(val == '0), 1'b0, 1'b1, 1'b0};
         end
         OP_OR: begin
            val = a | s;
            f   = {(val == '0), 3'b000};
         end
         OP_XOR: begin
            val = a ^ s;
            f   = {(val == '0), 3'b000};
         end
         OP_INC: begin
            val       = s + 8'd1;
            f         = {(val == '0), 1'b0, (s[3:0] == 4'hF), cin};
            write_acc = 1'b0;
         end
         OP_DEC: begin
            val       = s - 8'd1;
            f         = {(val == '0), 1'b1, (s[3:0] == 4'h0), cin};
            write_acc = 1'b0;
         end
         // Accumulator rotates always clear Z.
         OP_RLCA: begin
            val = {a[6:0], a[7]};
            f   = {3'b000, a[7]};
         end
         OP_RLA: begin
            val = {a[6:0], cin};
            f   = {3'b000, a[7]};
         end
         OP_RRCA: begin
            val = {a[0], a[7:1]};
            f   = {3'b000, a[0]};
         end
         OP_RRA: begin
            val = {cin, a[7:1]};
            f   = {3'b000, a[0]};
         end
         OP_RLC: begin
            val       = {s[6:0], s[7]};
            f         = {(val == '0), 2'b00, s[7]};
            write_acc = 1'b0;
         end
         OP_RL: begin
            val       = {s[6:0], cin};
            f         = {(val == '0), 2'b00, s[7]};
            write_acc = 1'b0;
         end
         OP_RRC: begin
            val       = {s[0], s[7:1]};
            f         = {(val == '0), 2'b00, s[0]};
            write_acc = 1'b0;
         end
         OP_RR: begin
            val       = {cin, s[7:1]};
            f         = {(val == '0), 2'b00, s[0]};
            write_acc = 1'b0;
         end
         OP_SLA: begin
            val       = {s[6:0], 1'b0};
            f         = {(val == '0), 2'b00, s[7]};
            write_acc = 1'b0;
         end
         OP_SRA: begin
            val       = {s[7], s[7:1]};
            f         = {(val == '0), 2'b00, s[0]};
            write_acc = 1'b0;
         end
         OP_SRL: begin
            val       = {1'b0, s[7:1]};
            f         = {(val == '0), 2'b00, s[0]};
            write_acc = 1'b0;
         end
         OP_SWAP: begin
            val       = {s[3:0], s[7:4]};
            f         = {(val == '0), 3'b000};
            write_acc = 1'b0;
         end
         OP_BIT: begin
            val       = s;
            f         = {((s & bmask) == '0), 1'b0, 1'b1, cin};
            write_acc = 1'b0;
         end
         OP_SET: begin
            val       = s | bmask;
            write_acc = 1'b0;
         end
         OP_RES: begin
            val       = s & ~bmask;
            write_acc = 1'b0;
         end
         OP_DAA: begin
            val = daa_r;
            f   = {(daa_r == '0), flags_ff[FLAG_N], 1'b0, daa_c};
         end
         OP_CPL: begin
            val = ~a;
            f   = {flags_ff[FLAG_Z], 1'b1, 1'b1, cin};
         end
         OP_CCF: begin
            f = {flags_ff[FLAG_Z], 2'b00, ~cin};
         end
         OP_SCF: begin
            f = {flags_ff[FLAG_Z], 2'b00, 1'b1};
         end
         OP_LOAD: begin
            val = s;
         end
         // Unused codes leave everything as it is.
         default: begin
            val = a;
            f   = flags_ff;
         end
      endcase

      acc_in   = write_acc ? val : acc_ff;
      flags_in = f;
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
      if (req_take) begin
         req_op_ff      <= req_bus.op;
         req_operand_ff <= req_bus.operand;
         req_bidx_ff    <= req_bus.bit_index;
      end
   end

   // Architectural state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            acc_ff       <= acc_in;
            flags_ff     <= flags_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_value_ff <= val;
         rsp_flags_ff <= f;
      end
   end

endmodule
